// ----- design/lvf_pkg.sv -----
// ----------------------------------------------------------------------------
// lvf_pkg
// Shared types and constants for the line-of-sight velocity vector fit.
// ----------------------------------------------------------------------------
`default_nettype none

package lvf_pkg;

	localparam int SAMPLES_DEF = 64;    // default sample store depth
	localparam int LU_W        = 112;   // long unit datapath width
	localparam int SUM_W       = 48;    // accumulator width
	localparam int ACC_W       = 64;    // residual square sum width
	localparam int MUL_W       = 27;    // shared short multiplier operand width
	localparam int STEP_W      = 7;     // long unit step counter width
	localparam int LIMIT       = 1000000;

	// long unit operations
	typedef enum logic [2:0] {
		LU_MUL  = 3'b001,
		LU_DIV  = 3'b010,
		LU_SQRT = 3'b100
	} lu_op_t;

	typedef struct packed {
		logic done;   // one cycle pulse, results valid
		logic sat;    // quotient would not fit the step count
		logic adj;    // rounding up for DIV, remainder above root for SQRT
	} lu_stat_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SINGULAR = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

// ----- design/lvf_cordic.sv -----
// ----------------------------------------------------------------------------
// lvf_cordic
// Iterative 16 step rotation unit: azimuth in hundredths of a degree to
// sine and cosine in Q14, folded to +-90 degrees and clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module lvf_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [16:0] azimuth,
	output logic                    done,
	output logic signed [15:0]      sine,
	output logic signed [15:0]      cosine
);

	function automatic logic signed [24:0] step_angle(input logic [3:0] i);
		unique case (i)
			4'd0:  step_angle = 25'sd1152000;
			4'd1:  step_angle = 25'sd680065;
			4'd2:  step_angle = 25'sd359328;
			4'd3:  step_angle = 25'sd182400;
			4'd4:  step_angle = 25'sd91554;
			4'd5:  step_angle = 25'sd45822;
			4'd6:  step_angle = 25'sd22916;
			4'd7:  step_angle = 25'sd11459;
			4'd8:  step_angle = 25'sd5730;
			4'd9:  step_angle = 25'sd2865;
			4'd10: step_angle = 25'sd1432;
			4'd11: step_angle = 25'sd716;
			4'd12: step_angle = 25'sd358;
			4'd13: step_angle = 25'sd179;
			4'd14: step_angle = 25'sd90;
			4'd15: step_angle = 25'sd45;
			default: step_angle = 25'sd0;
		endcase
	endfunction

	function automatic logic signed [15:0] fin(input logic signed [19:0] v, input logic flip);
		logic signed [19:0] r;
		logic signed [15:0] c;
		r = (v + 20'sd2) >>> 2;
		if (r > 20'sd16384)
			c = 16'sd16384;
		else if (r < -20'sd16384)
			c = -16'sd16384;
		else
			c = r[15:0];
		fin = flip ? -c : c;
	endfunction

	logic signed [18:0] t0, t1, a2, a3;
	logic               flip_n;
	logic signed [19:0] x_q, y_q, dx, dy;
	logic signed [24:0] z_q;
	logic [3:0]         i_q;
	logic               busy_q, done_q, flip_q;

	// fold to one turn, then to +-90 degrees
	always_comb begin
		t0 = 19'(azimuth) + (azimuth[16] ? 19'sd72000 : 19'sd0);
		priority if (t0 >= 19'sd108000)
			t1 = t0 - 19'sd108000;
		else if (t0 >= 19'sd72000)
			t1 = t0 - 19'sd72000;
		else if (t0 >= 19'sd36000)
			t1 = t0 - 19'sd36000;
		else
			t1 = t0;
		a2 = (t1 > 19'sd18000) ? t1 - 19'sd36000 : t1;
		flip_n = 1'b1;
		priority if (a2 > 19'sd9000)
			a3 = a2 - 19'sd18000;
		else if (a2 < -19'sd9000)
			a3 = a2 + 19'sd18000;
		else begin
			a3 = a2;
			flip_n = 1'b0;
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= 20'sd39797;
			y_q    <= '0;
			z_q    <= 25'(a3) <<< 8;
			flip_q <= flip_n;
		end else if (busy_q) begin
			if (!z_q[24]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_angle(i_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_angle(i_q);
			end
		end
	end

	assign done   = done_q;
	assign cosine = fin(x_q, flip_q);
	assign sine   = fin(y_q, flip_q);

endmodule

`default_nettype wire

// ----- design/lvf_long_unit.sv -----
// ----------------------------------------------------------------------------
// lvf_long_unit
// Shared bit-serial unit: shift-add multiply, restoring divide and
// integer square root over a wide word, one bit or bit pair per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lvf_long_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire lvf_pkg::lu_op_t              op,
	input  wire logic [lvf_pkg::LU_W-1:0]     a,
	input  wire logic [lvf_pkg::LU_W-1:0]     b,
	input  wire logic [lvf_pkg::STEP_W-1:0]   steps,
	output lvf_pkg::lu_stat_t                 stat,
	output logic [lvf_pkg::LU_W-1:0]          quot,
	output logic [lvf_pkg::LU_W-1:0]          rem
);

	localparam int W = lvf_pkg::LU_W;

	lvf_pkg::lu_op_t         op_q;
	logic [W-1:0]            rem_q, d_q, q_q;
	logic [W-1:0]            d_half, root_try;
	logic [lvf_pkg::STEP_W-1:0] cnt_q;
	logic                    busy_q, done_q, sat_q, adj;

	assign d_half   = d_q >> 1;
	assign root_try = q_q + d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lvf_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			sat_q <= 1'b0;
			unique case (op)
				lvf_pkg::LU_MUL: begin
					rem_q <= '0;
					d_q   <= a;
					q_q   <= b;
				end
				lvf_pkg::LU_DIV: begin
					rem_q <= a;
					d_q   <= b;
					q_q   <= '0;
					sat_q <= (a >= b);
				end
				lvf_pkg::LU_SQRT: begin
					rem_q <= a;
					d_q   <= W'(1) << 62;
					q_q   <= '0;
				end
				default: begin
					rem_q <= '0;
					d_q   <= '0;
					q_q   <= '0;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				lvf_pkg::LU_MUL: begin
					if (q_q[0])
						rem_q <= rem_q + d_q;
					d_q <= d_q << 1;
					q_q <= q_q >> 1;
				end
				lvf_pkg::LU_DIV: begin
					d_q <= d_half;
					if (rem_q >= d_half) begin
						rem_q <= rem_q - d_half;
						q_q   <= {q_q[W-2:0], 1'b1};
					end else begin
						q_q <= {q_q[W-2:0], 1'b0};
					end
				end
				lvf_pkg::LU_SQRT: begin
					d_q <= d_q >> 2;
					if (rem_q >= root_try) begin
						rem_q <= rem_q - root_try;
						q_q   <= (q_q >> 1) + d_q;
					end else begin
						q_q <= q_q >> 1;
					end
				end
				default: begin
					d_q <= d_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (op_q)
			lvf_pkg::LU_DIV:  adj = ({rem_q, 1'b0} >= {1'b0, d_q});
			lvf_pkg::LU_SQRT: adj = (rem_q > q_q);
			default:          adj = 1'b0;
		endcase
	end

	assign stat = '{done: done_q, sat: sat_q, adj: adj};
	assign quot = q_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- design/los_velocity_vector_fit.sv -----
// ----------------------------------------------------------------------------
// los_velocity_vector_fit
// Least-squares fit of v = A*cos(az) + P*sin(az) over a set of line-of-sight
// samples, with rms residual and component errors.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | azimuth, velocity, last_sample
//  out     | out_valid/out_stall | along_velocity, across_velocity, along_error,
//          |                     | across_error, rms_residual, status
//
//  A sample is accepted, turned in the rotation unit, then takes five multiply-
//  accumulates on the shared short multiplier; a sample dropped on a full
//  store is accepted but not stored. The closing sample adds the solve: six
//  48-step serial products and two 21-step divides, then per stored sample a
//  rotation and three residual terms, then a 64-step mean, roots, a product
//  and two error divides on the long unit's bit-serial steps.
//  Reset clears control, count and sums; the sample store keeps no reset.
//  in_stall is high whenever the sequencer is busy. A finished result waits
//  in the output register under out_stall while new samples are taken; the
//  next result waits for it to leave.
// ----------------------------------------------------------------------------
`default_nettype none

module los_velocity_vector_fit #(
	parameter int MAX_SAMPLES = lvf_pkg::SAMPLES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [16:0] azimuth,
	input  wire logic signed [16:0] velocity,
	input  wire logic               last_sample,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [20:0]      along_velocity,
	output logic signed [20:0]      across_velocity,
	output logic [19:0]             along_error,
	output logic [19:0]             across_error,
	output logic [19:0]             rms_residual,
	output logic [1:0]              status
);

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int W     = lvf_pkg::LU_W;
	localparam int SW    = lvf_pkg::SUM_W;
	localparam int MW    = lvf_pkg::MUL_W;
	localparam int E_W   = 38;

	typedef enum logic [15:0] {
		ST_IDLE   = 16'b0000_0000_0000_0001,
		ST_SINCOS = 16'b0000_0000_0000_0010,
		ST_MAC    = 16'b0000_0000_0000_0100,
		ST_FMUL   = 16'b0000_0000_0000_1000,
		ST_FCHK   = 16'b0000_0000_0001_0000,
		ST_FDIV   = 16'b0000_0000_0010_0000,
		ST_RREAD  = 16'b0000_0000_0100_0000,
		ST_RSTART = 16'b0000_0000_1000_0000,
		ST_RWAIT  = 16'b0000_0001_0000_0000,
		ST_RCALC  = 16'b0000_0010_0000_0000,
		ST_MEAN   = 16'b0000_0100_0000_0000,
		ST_ROOT   = 16'b0000_1000_0000_0000,
		ST_XMUL   = 16'b0001_0000_0000_0000,
		ST_EDIV   = 16'b0010_0000_0000_0000,
		ST_EROOT  = 16'b0100_0000_0000_0000,
		ST_DONE   = 16'b1000_0000_0000_0000
	} state_t;

	function automatic logic [SW-1:0] mag_s(input logic signed [SW-1:0] v);
		mag_s = v[SW-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
		mag_w = v[W-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	// sequencer
	state_t             st_q;
	logic               iss_q;          // start the long unit this cycle, except for a skipped error divide
	logic [CW-1:0]      cnt_q, k_q;
	logic               last_q, ovf_q;
	logic [2:0]         mi_q, fi_q;
	logic [1:0]         ri_q;
	logic               ei_q;

	// datapath
	logic signed [16:0]   v_q;
	logic signed [SW-1:0] ss_q, cs_q, xs_q, vs_q, vc_q;
	logic signed [W-1:0]  hold_q, den_q, num_q;
	logic signed [E_W-1:0] e_q;
	logic [lvf_pkg::ACC_W-1:0] acc_q;
	logic [31:0]          rq4_q;
	logic [W-1:0]         x_q;

	// result
	logic signed [20:0] along_q, across_q;
	logic [19:0]        aerr_q, perr_q, rms_q;
	logic [1:0]         stat_q;
	logic               ov_q;

	// sample store
	logic [16:0] maz [MAX_SAMPLES];
	logic [16:0] mvel [MAX_SAMPLES];
	logic signed [16:0] rd_az_q, rd_v_q;

	logic in_take, store_ok, out_load;
	assign in_stall = (st_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign store_ok = (cnt_q < CW'(MAX_SAMPLES));
	assign out_load = (st_q == ST_DONE) && (!ov_q || !out_stall);

	always_ff @(posedge clk) begin
		if (in_take && store_ok) begin
			maz[cnt_q[AW-1:0]]  <= azimuth;
			mvel[cnt_q[AW-1:0]] <= velocity;
		end
		rd_az_q <= maz[k_q[AW-1:0]];
		rd_v_q  <= mvel[k_q[AW-1:0]];
	end

	// rotation unit
	logic               cd_start, cd_done;
	logic signed [16:0] cd_az;
	logic signed [15:0] sin_w, cos_w;

	assign cd_start = (in_take && store_ok) || (st_q == ST_RSTART);
	assign cd_az    = (st_q == ST_RSTART) ? rd_az_q : azimuth;

	lvf_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cd_start),
		.azimuth (cd_az),
		.done    (cd_done),
		.sine    (sin_w),
		.cosine  (cos_w)
	);

	// shared short multiplier: sums per sample, residual terms per stored sample
	logic signed [MW-1:0]   ma, mb;
	logic signed [2*MW-1:0] prod;
	logic signed [E_W-1:0]  r_w;

	assign r_w = e_q >>> 10;

	always_comb begin
		ma = '0;
		mb = '0;
		if (st_q == ST_MAC) begin
			unique case (mi_q)
				3'd0: begin ma = MW'(sin_w); mb = MW'(sin_w); end
				3'd1: begin ma = MW'(cos_w); mb = MW'(cos_w); end
				3'd2: begin ma = MW'(sin_w); mb = MW'(cos_w); end
				3'd3: begin ma = MW'(v_q);   mb = MW'(sin_w); end
				3'd4: begin ma = MW'(v_q);   mb = MW'(cos_w); end
				default: begin ma = '0; mb = '0; end
			endcase
		end else if (st_q == ST_RCALC) begin
			unique case (ri_q)
				2'd0: begin ma = MW'(along_q);  mb = MW'(cos_w); end
				2'd1: begin ma = MW'(across_q); mb = MW'(sin_w); end
				2'd2: begin ma = MW'(r_w);      mb = MW'(r_w);   end
				default: begin ma = '0; mb = '0; end
			endcase
		end
	end

	assign prod = ma * mb;

	// long unit operand selection
	logic signed [SW-1:0] opa, opb, sum_e;
	logic                 sum_le0, lu_start;
	lvf_pkg::lu_op_t      lu_op;
	logic [W-1:0]         lu_a, lu_b, lu_q, lu_rem;
	logic [lvf_pkg::STEP_W-1:0] lu_steps;
	lvf_pkg::lu_stat_t    lu_stat;
	logic [40:0]          rq500;

	always_comb begin
		unique case (fi_q)
			3'd0:    begin opa = ss_q; opb = cs_q; end
			3'd1:    begin opa = xs_q; opb = xs_q; end
			3'd2:    begin opa = ss_q; opb = vc_q; end
			3'd3:    begin opa = xs_q; opb = vs_q; end
			3'd4:    begin opa = cs_q; opb = vs_q; end
			default: begin opa = xs_q; opb = vc_q; end
		endcase
	end

	// along error uses the cosine square sum, across error the sine one
	assign sum_e    = ei_q ? ss_q : cs_q;
	assign sum_le0  = sum_e[SW-1] || (sum_e == '0);
	assign lu_start = iss_q && !((st_q == ST_EDIV) && sum_le0);
	assign rq500    = 41'(rq4_q) * 41'd500;

	always_comb begin
		lu_op    = lvf_pkg::LU_MUL;
		lu_a     = W'(mag_s(opa));
		lu_b     = W'(mag_s(opb));
		lu_steps = lvf_pkg::STEP_W'(SW);
		unique case (st_q)
			ST_FDIV: begin
				lu_op    = lvf_pkg::LU_DIV;
				lu_a     = mag_w(num_q) << 14;
				lu_b     = unsigned'(den_q) << 21;
				lu_steps = lvf_pkg::STEP_W'(21);
			end
			ST_MEAN: begin
				lu_op    = lvf_pkg::LU_DIV;
				lu_a     = W'(acc_q);
				lu_b     = W'(cnt_q) << 64;
				lu_steps = lvf_pkg::STEP_W'(64);
			end
			ST_ROOT, ST_EROOT: begin
				lu_op    = lvf_pkg::LU_SQRT;
				lu_a     = lu_q;
				lu_steps = lvf_pkg::STEP_W'(32);
			end
			ST_XMUL: begin
				lu_op    = lvf_pkg::LU_MUL;
				lu_a     = W'(rq500);
				lu_b     = W'(cnt_q);
				lu_steps = lvf_pkg::STEP_W'(CW);
			end
			ST_EDIV: begin
				lu_op    = lvf_pkg::LU_DIV;
				lu_a     = x_q << 24;
				lu_b     = W'(unsigned'(sum_e)) << 42;
				lu_steps = lvf_pkg::STEP_W'(42);
			end
			default: begin
				lu_op = lvf_pkg::LU_MUL;
			end
		endcase
	end

	lvf_long_unit u_long (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lu_start),
		.op     (lu_op),
		.a      (lu_a),
		.b      (lu_b),
		.steps  (lu_steps),
		.stat   (lu_stat),
		.quot   (lu_q),
		.rem    (lu_rem)
	);

	// result shaping
	logic signed [W-1:0] prod_w;
	logic [W-1:0]        qr;
	logic [19:0]         fit_mag, lim_v;
	logic signed [20:0]  fit_v;
	logic [32:0]         rms_r;
	logic [19:0]         rms_v;

	assign prod_w  = (opa[SW-1] ^ opb[SW-1]) ? -signed'(lu_rem) : signed'(lu_rem);
	assign qr      = lu_q + W'(lu_stat.adj);
	assign lim_v   = 20'(lvf_pkg::LIMIT);
	assign fit_mag = (lu_stat.sat || qr > W'(lvf_pkg::LIMIT)) ? lim_v : qr[19:0];
	assign fit_v   = num_q[W-1] ? -signed'({1'b0, fit_mag}) : signed'({1'b0, fit_mag});
	assign rms_r   = ({1'b0, lu_q[31:0]} + 33'd8) >> 4;
	assign rms_v   = (rms_r > 33'(lvf_pkg::LIMIT)) ? lim_v : rms_r[19:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			iss_q  <= 1'b0;
			cnt_q  <= '0;
			k_q    <= '0;
			last_q <= 1'b0;
			ovf_q  <= 1'b0;
			mi_q   <= '0;
			fi_q   <= '0;
			ri_q   <= '0;
			ei_q   <= 1'b0;
			ss_q   <= '0;
			cs_q   <= '0;
			xs_q   <= '0;
			vs_q   <= '0;
			vc_q   <= '0;
			ov_q   <= 1'b0;
		end else begin
			iss_q <= 1'b0;
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_take) begin
						last_q <= last_sample;
						if (store_ok) begin
							cnt_q <= cnt_q + 1'b1;
							st_q  <= ST_SINCOS;
						end else begin
							ovf_q <= 1'b1;
							if (last_sample)
								st_q <= ST_DONE;
						end
					end
				end
				ST_SINCOS: begin
					if (cd_done) begin
						mi_q <= '0;
						st_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					mi_q <= mi_q + 3'd1;
					unique case (mi_q)
						3'd0: ss_q <= ss_q + SW'(prod);
						3'd1: cs_q <= cs_q + SW'(prod);
						3'd2: xs_q <= xs_q + SW'(prod);
						3'd3: vs_q <= vs_q + SW'(prod);
						default: begin
							vc_q <= vc_q + SW'(prod);
							if (!last_q)
								st_q <= ST_IDLE;
							else if (ovf_q)
								st_q <= ST_DONE;
							else begin
								fi_q  <= '0;
								iss_q <= 1'b1;
								st_q  <= ST_FMUL;
							end
						end
					endcase
				end
				ST_FMUL: begin
					if (lu_stat.done) begin
						fi_q <= fi_q + 3'd1;
						unique case (fi_q)
							3'd1: st_q <= ST_FCHK;
							3'd3, 3'd5: begin
								iss_q <= 1'b1;
								st_q  <= ST_FDIV;
							end
							default: iss_q <= 1'b1;
						endcase
					end
				end
				ST_FCHK: begin
					if (den_q[W-1] || den_q == '0 || cnt_q == '0)
						st_q <= ST_DONE;
					else begin
						fi_q  <= 3'd2;
						iss_q <= 1'b1;
						st_q  <= ST_FMUL;
					end
				end
				ST_FDIV: begin
					if (lu_stat.done) begin
						if (fi_q == 3'd4) begin
							iss_q <= 1'b1;
							st_q  <= ST_FMUL;
						end else begin
							k_q  <= '0;
							st_q <= ST_RREAD;
						end
					end
				end
				ST_RREAD:  st_q <= ST_RSTART;
				ST_RSTART: st_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (cd_done) begin
						ri_q <= '0;
						st_q <= ST_RCALC;
					end
				end
				ST_RCALC: begin
					ri_q <= ri_q + 2'd1;
					if (ri_q == 2'd2) begin
						k_q <= k_q + 1'b1;
						if (k_q + 1'b1 == cnt_q) begin
							iss_q <= 1'b1;
							st_q  <= ST_MEAN;
						end else
							st_q <= ST_RREAD;
					end
				end
				ST_MEAN: begin
					if (lu_stat.done) begin
						iss_q <= 1'b1;
						st_q  <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (lu_stat.done) begin
						iss_q <= 1'b1;
						st_q  <= ST_XMUL;
					end
				end
				ST_XMUL: begin
					if (lu_stat.done) begin
						ei_q  <= 1'b0;
						iss_q <= 1'b1;
						st_q  <= ST_EDIV;
					end
				end
				ST_EDIV: begin
					if ((iss_q && sum_le0) || (lu_stat.done && lu_stat.sat)) begin
						// error saturates; move on to the next component, or finish after the across one
						if (!ei_q) begin
							ei_q  <= 1'b1;
							iss_q <= 1'b1;
						end else
							st_q <= ST_DONE;
					end else if (lu_stat.done) begin
						iss_q <= 1'b1;
						st_q  <= ST_EROOT;
					end
				end
				ST_EROOT: begin
					if (lu_stat.done) begin
						if (!ei_q) begin
							ei_q  <= 1'b1;
							iss_q <= 1'b1;
							st_q  <= ST_EDIV;
						end else
							st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						ov_q  <= 1'b1;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						ss_q  <= '0;
						cs_q  <= '0;
						xs_q  <= '0;
						vs_q  <= '0;
						vc_q  <= '0;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			along_q  <= '0;
			across_q <= '0;
			aerr_q   <= '0;
			perr_q   <= '0;
			rms_q    <= '0;
			stat_q   <= store_ok ? lvf_pkg::STATUS_OK : lvf_pkg::STATUS_OVERFLOW;
			v_q      <= velocity;
		end
		if (st_q == ST_MAC && mi_q == 3'd4 && last_q && ovf_q)
			stat_q <= lvf_pkg::STATUS_OVERFLOW;
		if (st_q == ST_FCHK && (den_q[W-1] || den_q == '0 || cnt_q == '0))
			stat_q <= lvf_pkg::STATUS_SINGULAR;
		if (st_q == ST_FMUL && lu_stat.done) begin
			unique case (fi_q)
				3'd1:       den_q  <= hold_q - prod_w;
				3'd3, 3'd5: num_q  <= hold_q - prod_w;
				default:    hold_q <= prod_w;
			endcase
		end
		if (st_q == ST_FDIV && lu_stat.done) begin
			if (fi_q == 3'd4)
				along_q <= fit_v;
			else
				across_q <= fit_v;
			acc_q <= '0;
		end
		if (st_q == ST_RSTART)
			v_q <= rd_v_q;
		if (st_q == ST_RCALC) begin
			unique case (ri_q)
				2'd0: e_q <= (E_W'(v_q) <<< 14) + E_W'(512) - E_W'(prod);
				2'd1: e_q <= e_q - E_W'(prod);
				default: acc_q <= acc_q + lvf_pkg::ACC_W'(unsigned'(prod));
			endcase
		end
		if (st_q == ST_ROOT && lu_stat.done) begin
			rq4_q <= lu_q[31:0];
			rms_q <= rms_v;
		end
		if (st_q == ST_XMUL && lu_stat.done)
			x_q <= lu_rem;
		if (st_q == ST_EDIV && ((iss_q && sum_le0) || (lu_stat.done && lu_stat.sat))) begin
			if (ei_q)
				perr_q <= lim_v;
			else
				aerr_q <= lim_v;
		end
		if (st_q == ST_EROOT && lu_stat.done) begin
			if (ei_q)
				perr_q <= (qr > W'(lvf_pkg::LIMIT)) ? lim_v : qr[19:0];
			else
				aerr_q <= (qr > W'(lvf_pkg::LIMIT)) ? lim_v : qr[19:0];
		end
		if (out_load) begin
			along_velocity  <= along_q;
			across_velocity <= across_q;
			along_error     <= aerr_q;
			across_error    <= perr_q;
			rms_residual    <= rms_q;
			status          <= stat_q;
		end
	end

	assign out_valid = ov_q;

endmodule

`default_nettype wire
